FILE: design/bffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned MapWordBits = 8;
  localparam int unsigned DivWidth    = 33;
  localparam int unsigned UnitWidth   = 17;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  localparam logic [1:0] REG_MANAGED_BASE = 2'd0;
  localparam logic [1:0] REG_UNIT_BYTES   = 2'd1;
  localparam logic [1:0] REG_MAP_BYTES    = 2'd2;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_CLEAR    = 11'b00000000010,
    ST_DIV      = 11'b00000000100,
    ST_DECIDE   = 11'b00000001000,
    ST_SCAN     = 11'b00000010000,
    ST_MARK_LEN = 11'b00000100000,
    ST_MARK_RD  = 11'b00001000000,
    ST_MARK_WR  = 11'b00010000000,
    ST_FREE_RD  = 11'b00100000000,
    ST_FREE_LEN = 11'b01000000000,
    ST_RESP     = 11'b10000000000
  } bffa_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } bffa_div_ctl_t;

endpackage
`default_nettype wire

FILE: design/bffa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/bffa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bffa_div
  import bffa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DivWidth-1:0]  dividend_i,
  input  wire logic [UnitWidth-1:0] divisor_i,
  output logic                      done_o,
  output logic      [DivWidth-1:0]  quo_o,
  output logic      [UnitWidth-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DivWidth + 1);

  logic [DivWidth-1:0]  quo_q, quo_d;
  logic [UnitWidth:0]   rem_q, rem_d;
  logic [UnitWidth-1:0] dvs_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [UnitWidth:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[UnitWidth-1:0], quo_q[DivWidth-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(DivWidth);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[DivWidth-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[UnitWidth-1:0];

endmodule
`default_nettype wire

FILE: design/bitmap_first_fit_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top
// First-fit allocator over a used-bit map with per-run length store.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. command_i 0
// allocates request_bytes_i bytes (plus a 4-byte header), 1 frees
// user_address_i. Each command gives one result, shown for one cycle with
// done_o high; the receiver always takes it.
// Each command first runs through the divider. An allocate then reads the
// used map one 8-unit word per cycle from unit 0, and marks the run with
// a read and a write per map word. A free reads the stored length and
// clears its run the same way. One command is in flight at a time.
// Registers are written through the cfg channel (cfg_ready_o is always
// high); the user must write them only while busy_o is low, and the block
// itself does not enforce it.
// After reset the used map is cleared one word per cycle, all NUM_UNITS/8
// words, with busy_o high.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_top
  import bffa_pkg::*;
#(
  parameter int unsigned NUM_UNITS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [31:0] request_bytes_i,
  input  wire logic [31:0] user_address_i,
  output logic             done_o,
  output logic      [1:0]  status_o,
  output logic      [31:0] result_address_o,
  output logic      [12:0] units_affected_o,
  output logic      [11:0] start_unit_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned IW     = $clog2(NUM_UNITS + 1);
  localparam int unsigned WDEPTH = NUM_UNITS / MapWordBits;
  localparam int unsigned WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned UAW    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int unsigned PW     = IW + UnitWidth;

  bffa_state_e state_q, state_d;

  logic [31:0]          base_q;
  logic [16:0]          unit_q;
  logic [9:0]           mapb_q;
  logic [UnitWidth-1:0] unit_eff;
  logic [IW-1:0]        lim_units, lim_words;
  logic [12:0]          mapb_x8;

  logic                 accept;
  logic                 cmd_q;
  logic [1:0]           status_q;
  logic [IW-1:0]        units_q, start_q;
  logic [IW-1:0]        need_q, run_q, first_q, lo_q, hi_q;
  logic [IW-1:0]        raddr_q, ev_word_q, mw_q, clr_q;
  logic                 pend_q;
  logic [PW-1:0]        prod_q;

  bffa_div_ctl_t        div_ctl;
  logic [DivWidth-1:0]  dividend, quo;
  logic [UnitWidth-1:0] rem;
  logic [DivWidth:0]    need_full;

  logic                 map_we;
  logic [WAW-1:0]       map_waddr, map_raddr;
  logic [7:0]           map_wdata, map_rdata, mask;
  logic                 len_we;
  logic [IW-1:0]        len_rdata;

  logic                 fnd;
  logic [IW-1:0]        run_v, first_v, last_v, ubase, uidx;
  logic [IW:0]          end_v;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      unit_q <= 17'd8;
      mapb_q <= 10'd512;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MANAGED_BASE: base_q <= cfg_data_i;
        REG_UNIT_BYTES:   unit_q <= cfg_data_i[16:0];
        REG_MAP_BYTES:    mapb_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign unit_eff  = (unit_q == '0) ? UnitWidth'(1) : unit_q;
  assign mapb_x8   = {mapb_q, 3'b000};
  assign lim_units = (32'(mapb_x8) > NUM_UNITS) ? IW'(NUM_UNITS) : IW'(mapb_x8);
  assign lim_words = lim_units >> 3;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign dividend = (command_i == CMD_ALLOC)
                  ? ({1'b0, request_bytes_i} + DivWidth'(HeaderBytes))
                  : {1'b0, user_address_i - base_q - 32'(HeaderBytes)};
  assign div_ctl.start = accept;

  bffa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (dividend),
    .divisor_i  (unit_eff),
    .done_o     (div_ctl.done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign need_full = {1'b0, quo} + {{DivWidth{1'b0}}, (rem != '0)};

  // scan of one map word for the first free run
  always_comb begin
    run_v   = run_q;
    first_v = first_q;
    last_v  = first_q;
    fnd     = 1'b0;
    ubase   = ev_word_q << 3;
    for (int b = 0; b < MapWordBits; b++) begin
      if (!fnd) begin
        if (!map_rdata[b]) begin
          if (run_v == '0) begin
            first_v = ubase + IW'(b);
          end
          run_v = run_v + 1'b1;
        end else begin
          run_v = '0;
        end
        if (run_v == need_q) begin
          fnd    = 1'b1;
          last_v = ubase + IW'(b);
        end
      end
    end
  end

  always_comb begin
    for (int b = 0; b < MapWordBits; b++) begin
      uidx    = (mw_q << 3) + IW'(b);
      mask[b] = (uidx >= lo_q) && (uidx <= hi_q);
    end
  end

  assign end_v = ({1'b0, start_q} + {1'b0, len_rdata} > (IW + 1)'(NUM_UNITS))
               ? (IW + 1)'(NUM_UNITS) : ({1'b0, start_q} + {1'b0, len_rdata});

  always_comb begin
    map_we    = 1'b0;
    map_waddr = WAW'(mw_q);
    map_wdata = cmd_q == CMD_ALLOC ? (map_rdata | mask) : (map_rdata & ~mask);
    map_raddr = (state_q == ST_SCAN) ? WAW'(raddr_q) : WAW'(mw_q);
    if (state_q == ST_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = WAW'(clr_q);
      map_wdata = '0;
    end else if (state_q == ST_MARK_WR) begin
      map_we = 1'b1;
    end
  end

  assign len_we = (state_q == ST_MARK_LEN);

  bffa_ram #(.WIDTH(MapWordBits), .DEPTH(WDEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bffa_ram #(.WIDTH(IW), .DEPTH(NUM_UNITS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (UAW'(first_q)),
    .wdata_i (need_q),
    .raddr_i (UAW'(start_q)),
    .rdata_o (len_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_DIV;
      ST_CLEAR:    if (clr_q == IW'(WDEPTH - 1)) state_d = ST_IDLE;
      ST_DIV:      if (div_ctl.done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (cmd_q == CMD_ALLOC) begin
          state_d = (need_full > (DivWidth + 1)'(lim_units)) ? ST_RESP : ST_SCAN;
        end else begin
          state_d = (quo >= DivWidth'(lim_units)) ? ST_RESP : ST_FREE_RD;
        end
      end
      ST_SCAN: begin
        if (pend_q && fnd) state_d = ST_MARK_LEN;
        else if (pend_q && ev_word_q == lim_words - 1'b1) state_d = ST_RESP;
      end
      ST_MARK_LEN: state_d = ST_MARK_RD;
      ST_MARK_RD:  state_d = ST_MARK_WR;
      ST_MARK_WR:  state_d = (mw_q == (hi_q >> 3)) ? ST_RESP : ST_MARK_RD;
      ST_FREE_RD:  state_d = ST_FREE_LEN;
      ST_FREE_LEN: state_d = (len_rdata == '0) ? ST_RESP : ST_MARK_RD;
      ST_RESP:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(first_q * unit_eff);
    case (state_q)
      ST_IDLE: begin
        if (accept) cmd_q <= command_i;
      end
      ST_DECIDE: begin
        status_q <= STATUS_OK;
        units_q  <= '0;
        start_q  <= '0;
        raddr_q  <= '0;
        pend_q   <= 1'b0;
        run_q    <= '0;
        first_q  <= '0;
        need_q   <= IW'(need_full);
        if (cmd_q == CMD_ALLOC) begin
          if (need_full > (DivWidth + 1)'(lim_units)) status_q <= STATUS_NO_SPACE;
        end else if (quo >= DivWidth'(lim_units)) begin
          status_q <= STATUS_BAD_FREE;
        end else begin
          start_q <= IW'(quo);
        end
      end
      ST_SCAN: begin
        pend_q    <= (raddr_q < lim_words);
        ev_word_q <= raddr_q;
        raddr_q   <= raddr_q + 1'b1;
        if (pend_q) begin
          run_q   <= run_v;
          first_q <= first_v;
          if (fnd) begin
            lo_q    <= first_v;
            hi_q    <= last_v;
            mw_q    <= first_v >> 3;
            units_q <= need_q;
            start_q <= first_v;
          end else if (ev_word_q == lim_words - 1'b1) begin
            status_q <= STATUS_NO_SPACE;
          end
        end
      end
      ST_FREE_LEN: begin
        lo_q    <= start_q;
        hi_q    <= IW'(end_v - 1'b1);
        mw_q    <= start_q >> 3;
        units_q <= IW'(end_v - {1'b0, start_q});
      end
      ST_MARK_WR: begin
        mw_q <= mw_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o           = (state_q == ST_RESP);
  assign status_o         = status_q;
  assign result_address_o = (cmd_q == CMD_ALLOC && status_q == STATUS_OK)
                          ? (base_q + 32'(prod_q) + 32'(HeaderBytes)) : 32'd0;
  assign units_affected_o = 13'(units_q);
  assign start_unit_o     = 12'(start_q);

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("not busy after command transaction");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |->
      (result_address_o == 32'd0 && units_affected_o == 13'd0 && start_unit_o == 12'd0))
    else $error("failed result carries nonzero fields");

  a_map_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK_WR) |-> $past(state_q == ST_MARK_RD))
    else $error("map write without preceding read");

endmodule
`default_nettype wire

FILE: test/bitmap_first_fit_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top_test
// Drives allocate and free commands with random gaps under several
// register settings, predicts every result from a private copy of the used
// map and run lengths, and compares each done_o transaction field by field.
// ----------------------------------------------------------------------------

class alloc_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [12:0] units;
    logic [11:0] start;
  } alloc_result_t;

  bit            used_bits[4096];
  bit            written[4096];
  logic [12:0]   run_len[4096];
  logic [31:0]   base_q;
  logic [16:0]   unit_q;
  logic [9:0]    map_bytes_q;
  alloc_result_t pending[$];
  int            errors;
  logic [31:0]   granted[$];

  function new();
    base_q = 0;
    unit_q = 17'd8;
    map_bytes_q = 10'd512;
    errors = 0;
    foreach (run_len[i]) run_len[i] = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    if (idx == bffa_pkg::REG_MANAGED_BASE) base_q = data;
    else if (idx == bffa_pkg::REG_UNIT_BYTES) unit_q = data[16:0];
    else if (idx == bffa_pkg::REG_MAP_BYTES) map_bytes_q = data[9:0];
  endfunction

  function int unsigned scan_limit();
    int unsigned n;
    n = map_bytes_q * 8;
    return (n > 4096) ? 4096 : n;
  endfunction

  // a free is safe when it is out of range or hits a start that was written
  function bit free_is_safe(logic [31:0] uaddr);
    longint unsigned u, off, st;
    u = (unit_q == 0) ? 1 : unit_q;
    off = (uaddr - base_q - 32'd4) & 32'hffffffff;
    st = off / u;
    if (st >= scan_limit()) return 1;
    return written[st];
  endfunction

  function void note_command(logic cmd, logic [31:0] req, logic [31:0] uaddr);
    alloc_result_t r;
    longint unsigned u, bytes, need, off, st;
    int unsigned lim, run, first;
    bit found;
    r = '0;
    u = (unit_q == 0) ? 1 : unit_q;
    lim = scan_limit();
    if (cmd == bffa_pkg::CMD_ALLOC) begin
      bytes = longint'(req) + 4;
      need = (bytes + u - 1) / u;
      r.status = bffa_pkg::STATUS_NO_SPACE;
      if (need != 0 && need <= lim) begin
        run = 0;
        first = 0;
        found = 0;
        for (int k = 0; k < lim && !found; k++) begin
          if (!used_bits[k]) begin
            if (run == 0) first = k;
            run++;
          end else begin
            run = 0;
          end
          if (run == need) begin
            found = 1;
            for (int j = first; j <= k; j++) used_bits[j] = 1;
            run_len[first] = run;
            written[first] = 1;
            r.status = bffa_pkg::STATUS_OK;
            r.addr = base_q + first * u + 4;
            r.units = run;
            r.start = first;
            granted.push_back(r.addr);
          end
        end
      end
    end else begin
      off = (uaddr - base_q - 32'd4) & 32'hffffffff;
      st = off / u;
      if (st >= lim) begin
        r.status = bffa_pkg::STATUS_BAD_FREE;
      end else begin
        r.status = bffa_pkg::STATUS_OK;
        r.start = st;
        for (int k = 0; k < run_len[st] && st + k < 4096; k++) begin
          used_bits[st + k] = 0;
          r.units++;
        end
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [1:0] s, logic [31:0] a, logic [12:0] n, logic [11:0] f);
    alloc_result_t e;
    if (pending.size() == 0) begin
      $display("%0t unexpected result status %0d", $time, s);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.status !== s) begin
      $display("%0t status exp %0d got %0d", $time, e.status, s);
      errors++;
    end
    if (e.addr !== a) begin
      $display("%0t address exp %h got %h", $time, e.addr, a);
      errors++;
    end
    if (e.units !== n) begin
      $display("%0t units exp %0d got %0d", $time, e.units, n);
      errors++;
    end
    if (e.start !== f) begin
      $display("%0t start exp %0d got %0d", $time, e.start, f);
      errors++;
    end
  endfunction
endclass

module bitmap_first_fit_allocator_top_test;
  import bffa_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        command_i = 0;
  logic [31:0] request_bytes_i = 0;
  logic [31:0] user_address_i = 0;
  logic        cfg_valid_i = 0;
  logic [1:0]  cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        busy_o, done_o, cfg_ready_o;
  logic [1:0]  status_o;
  logic [31:0] result_address_o;
  logic [12:0] units_affected_o;
  logic [11:0] start_unit_o;
  longint      cycle_count = 0;
  alloc_scoreboard sb;

  bitmap_first_fit_allocator_top uut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("bitmap_first_fit_allocator_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, result_address_o, units_affected_o, start_unit_o);
  end

  // start_i stays high after a transaction until the next gap or drain
  task automatic send_cmd(logic cmd, logic [31:0] req, logic [31:0] ua);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    command_i <= cmd;
    request_bytes_i <= req;
    user_address_i <= ua;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(cmd, req, ua);
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic free_one();
    int i;
    logic [31:0] a;
    if (sb.granted.size() == 0) begin
      send_cmd(CMD_FREE, $urandom, sb.base_q - 32'd4);
      return;
    end
    i = $urandom_range(0, sb.granted.size() - 1);
    a = sb.granted[i];
    sb.granted.delete(i);
    send_cmd(CMD_FREE, $urandom, a);
  endtask

  task automatic random_phase(int count, int unsigned max_req);
    int r;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_cmd(CMD_ALLOC, $urandom_range(0, max_req), $urandom);
      else if (r < 90) free_one();
      else if (r < 95) send_cmd(CMD_ALLOC, $urandom, $urandom);
      else begin
        a = $urandom;
        if (!sb.free_is_safe(a)) a = sb.base_q - 32'd4;
        send_cmd(CMD_FREE, $urandom, a);
      end
    end
  endtask

  task automatic new_setting(logic [31:0] base, logic [31:0] unit, logic [31:0] mb);
    drain();
    while (sb.granted.size() != 0) free_one();
    drain();
    write_cfg(REG_MANAGED_BASE, base);
    write_cfg(REG_UNIT_BYTES, unit);
    write_cfg(REG_MAP_BYTES, mb);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_ALLOC, 4, 32'hffffffff);
    send_cmd(CMD_ALLOC, 5, 0);
    send_cmd(CMD_ALLOC, 32'hfffffffb, 0);
    send_cmd(CMD_ALLOC, 32'hffffffff, 0);
    send_cmd(CMD_ALLOC, 4096 * 8 - 4, 0);
    send_cmd(CMD_ALLOC, 100, 0);
    free_one();
    free_one();
    send_cmd(CMD_FREE, 0, 32'd4);
    send_cmd(CMD_FREE, 0, 32'd4);
    send_cmd(CMD_FREE, 0, 32'd0);
    send_cmd(CMD_FREE, 0, 32'd4 + 4096 * 8);
    send_cmd(CMD_FREE, 32'hffffffff, 32'hffffffff);
    random_phase(300, 200);
    new_setting(32'hfffffff0, 0, 1);
    send_cmd(CMD_ALLOC, 3, 0);
    send_cmd(CMD_ALLOC, 0, 0);
    random_phase(250, 10);
    new_setting(32'h8000_0000, 17'h1ffff, 0);
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_FREE, 0, 32'h8000_0004);
    new_setting(32'h1234_5678, 65536, 1023);
    random_phase(250, 2000000);
    new_setting($urandom, $urandom_range(1, 64), $urandom_range(2, 64));
    random_phase(250, 1000);
    new_setting(0, 1, 512);
    random_phase(250, 300);
    drain();
    if (sb.errors == 0) begin
      $display("bitmap_first_fit_allocator_top regression: pass");
    end else begin
      $display("bitmap_first_fit_allocator_top regression: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_div.sv
design/bitmap_first_fit_allocator_top.sv
test/bitmap_first_fit_allocator_top_test.sv
